// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TWIL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TWIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/twil_pkg.sv =====
// ---------------------------------------------------------------------------
// twil_pkg
// Shared constants, types and the letter decode for the trie unit.
// ---------------------------------------------------------------------------
`default_nettype none

package twil_pkg;

  localparam int TWIL_MAX_NODES = 1024;
  localparam int TWIL_ALPHABET  = 52;
  localparam int TWIL_LETTERS   = 26;
  localparam int TWIL_IDX_W     = 6;

  localparam logic [7:0] LOWER_BASE = 8'd97;
  localparam logic [7:0] UPPER_BASE = 8'd65;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_POOL    = 2'd2
  } status_t;

  typedef struct packed {
    logic                  ok;
    logic [TWIL_IDX_W-1:0] idx;
  } letter_t;

  function automatic letter_t letter_decode(input logic [7:0] ch);
    letter_t    res;
    logic [7:0] lo;
    logic [7:0] up;
    lo = ch - LOWER_BASE;
    up = ch - UPPER_BASE;
    res.ok  = 1'b0;
    res.idx = '0;
    if (ch >= LOWER_BASE && lo < 8'(TWIL_LETTERS)) begin
      res.ok  = 1'b1;
      res.idx = lo[TWIL_IDX_W-1:0];
    end else if (ch >= UPPER_BASE && up < 8'(TWIL_LETTERS)) begin
      res.ok  = 1'b1;
      res.idx = TWIL_IDX_W'(up + 8'(TWIL_LETTERS));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/twil_ram.sv =====
// ---------------------------------------------------------------------------
// twil_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module twil_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/trie_word_insert_lookup_unit.sv =====
// ---------------------------------------------------------------------------
// trie_word_insert_lookup_unit
// Dictionary trie: character-serial insert and search over 52 letters.
// ---------------------------------------------------------------------------
// After reset the unit sweeps both tables clean, one child-table entry per
// cycle, over all MAX_NODES*52 entries, with in_tready low. Then each
// character takes a child-table read in S_IDLE, then the walk step with an
// optional child write in S_WALK; a last character then passes S_MARK for
// the word-mark result and the result beat, held there while out_tready is low.
// With the single child-table read port, a new character is taken only in S_IDLE.
`default_nettype none

module trie_word_insert_lookup_unit
  import twil_pkg::*;
#(
  parameter int MAX_NODES = TWIL_MAX_NODES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] letter
  input  wire logic [0:0] in_tuser,   // [0] cmd
  input  wire logic       in_tlast,   // last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [0] found, [2:1] status, [7:3] zero
  output logic      [0:0] out_tuser   // [0] was_search
);

  localparam int CT_DEPTH = MAX_NODES * TWIL_ALPHABET;
  localparam int CT_AW    = $clog2(CT_DEPTH);
  localparam int NODE_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int FREE_W   = $clog2(MAX_NODES + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_MARK
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CT_AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [NODE_W-1:0]       cur_r, cur_nxt;
  logic [FREE_W-1:0]       free_r, free_nxt;
  logic                    miss_r, miss_nxt;
  status_t                 err_r, err_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  status_t                 status_r, status_nxt;
  cmd_t                    was_r, was_nxt;

  logic [CT_AW-1:0]        addr_r, addr_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic                    last_r, last_nxt;
  logic                    good_r, good_nxt;

  letter_t                 dec;
  logic [CT_AW-1:0]        ch_raddr;
  logic                    ch_re, ch_we;
  logic [CT_AW-1:0]        ch_waddr;
  logic [NODE_W-1:0]       ch_wdata, ch_rdata;
  logic                    mk_re, mk_we;
  logic [NODE_W-1:0]       mk_raddr, mk_waddr;
  logic                    mk_wdata;
  logic                    mk_rdata;
  logic                    out_free;
  logic                    walk_alloc;

  assign dec      = letter_decode(in_tdata);
  assign ch_raddr = CT_AW'(cur_r) * CT_AW'(TWIL_ALPHABET) + CT_AW'(dec.idx);
  assign out_free = !out_valid_r || out_tready;

  twil_ram #(
    .DEPTH (CT_DEPTH),
    .WIDTH (NODE_W)
  ) u_child (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (ch_re),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  twil_ram #(
    .DEPTH (MAX_NODES),
    .WIDTH (1)
  ) u_mark (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .re    (mk_re),
    .raddr (mk_raddr),
    .rdata (mk_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    free_nxt      = free_r;
    miss_nxt      = miss_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    was_nxt       = was_r;
    addr_nxt      = addr_r;
    cmd_nxt       = cmd_r;
    last_nxt      = last_r;
    good_nxt      = good_r;
    ch_re         = 1'b0;
    ch_we         = 1'b0;
    ch_waddr      = addr_r;
    ch_wdata      = free_r[NODE_W-1:0];
    mk_re         = 1'b0;
    mk_we         = 1'b0;
    mk_raddr      = cur_r;
    mk_waddr      = cur_r;
    mk_wdata      = 1'b1;
    walk_alloc    = 1'b0;

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ch_we    = 1'b1;
        ch_waddr = clr_cnt_r;
        ch_wdata = '0;
        mk_we    = (clr_cnt_r < CT_AW'(MAX_NODES));
        mk_waddr = clr_cnt_r[NODE_W-1:0];
        mk_wdata = 1'b0;
        if (clr_cnt_r == CT_AW'(CT_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + CT_AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ch_re    = 1'b1;
          addr_nxt = ch_raddr;
          cmd_nxt  = cmd_t'(in_tuser[0]);
          last_nxt = in_tlast;
          if (!dec.ok && err_r == ST_OK) begin
            err_nxt = ST_BADCHAR;
          end
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (err_r == ST_OK && !miss_r) begin
          if (ch_rdata != '0) begin
            cur_nxt = ch_rdata;
          end else if (cmd_r == CMD_SEARCH) begin
            miss_nxt = 1'b1;
          end else if (free_r < FREE_W'(MAX_NODES)) begin
            ch_we      = 1'b1;
            walk_alloc = 1'b1;
            cur_nxt    = free_r[NODE_W-1:0];
            free_nxt   = free_r + FREE_W'(1);
          end else begin
            err_nxt = ST_POOL;
          end
        end
        good_nxt = (err_nxt == ST_OK) && !miss_nxt;
        mk_raddr = cur_nxt;
        mk_waddr = cur_nxt;
        if (last_r) begin
          if (cmd_r == CMD_SEARCH) begin
            mk_re = 1'b1;
          end else begin
            mk_we = good_nxt;
          end
          state_nxt = S_MARK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          found_nxt     = (cmd_r == CMD_SEARCH) && good_r && mk_rdata;
          status_nxt    = err_r;
          was_nxt       = cmd_r;
          cur_nxt       = '0;
          miss_nxt      = 1'b0;
          err_nxt       = ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cur_r       <= '0;
      free_r      <= FREE_W'(1);
      miss_r      <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_r       <= cur_nxt;
      free_r      <= free_nxt;
      miss_r      <= miss_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    cmd_r    <= cmd_nxt;
    last_r   <= last_nxt;
    good_r   <= good_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    was_r    <= was_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, status_r, found_r};
  assign out_tuser  = was_r;

`include "assert_macros.svh"

  `TWIL_ASSERT_IMPL(a_free_range, clk, rst_n, 1'b1,
                    free_r != '0 && free_r <= FREE_W'(MAX_NODES))
  `TWIL_ASSERT_IMPL(a_alloc_room, clk, rst_n, walk_alloc, free_r < FREE_W'(MAX_NODES))
  `TWIL_ASSERT_NEXT(a_result_src, clk, rst_n, state_r != S_MARK && !out_valid_r,
                    !out_valid_r)
  `TWIL_ASSERT_NEXT(a_clear_idle, clk, rst_n, state_r == S_CLEAR, cur_r == '0 && !out_valid_r)

endmodule

`default_nettype wire
